@@ hw/rtl/lcdt_pkg.sv @@
// lcdt_pkg: constants and types shared by the lcd scan-line mode timer
// used by the channel interfaces and the top level; no dependencies
package lcdt_pkg;

  localparam int unsigned OAM_DOTS      = 80;
  localparam int unsigned DRAW_DOTS     = 172;
  localparam int unsigned HBLANK_DOTS   = 204;
  localparam int unsigned VISIBLE_LINES = 144;
  localparam int unsigned LAST_LINE     = 153;
  localparam int unsigned LINE_DOTS     = 456;

  localparam int unsigned DOT_W   = 13;
  localparam int unsigned LINE_W  = 8;
  localparam int unsigned PHASE_W = 10;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_ENABLE   = 2'd0,
    REG_LINE_COMPARE     = 2'd1,
    REG_MATCH_IRQ_ENABLE = 2'd2,
    REG_NONE             = 2'd3
  } reg_idx_t;

endpackage

@@ hw/rtl/lcdt_in_if.sv @@
// lcdt_in_if: tick channel into the mode timer (valid, ready, halted flag)
// depends on lcdt_pkg
interface lcdt_in_if;
  import lcdt_pkg::*;

  logic valid;
  logic ready;
  logic halted;

  modport source (output valid, output halted, input ready);
  modport sink (input valid, input halted, output ready);
endinterface

@@ hw/rtl/lcdt_out_if.sv @@
// lcdt_out_if: result channel out of the mode timer (mode, line, flags)
// depends on lcdt_pkg
interface lcdt_out_if;
  import lcdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LINE_W-1:0] line;
  logic              line_match;
  logic              vblank_irq;
  logic              stat_irq;
  logic              line_end;

  modport source (
    output valid, output mode, output line, output line_match,
    output vblank_irq, output stat_irq, output line_end, input ready
  );
  modport sink (
    input valid, input mode, input line, input line_match,
    input vblank_irq, input stat_irq, input line_end, output ready
  );
endinterface

@@ hw/rtl/lcd_scanline_mode_timer_top.sv @@
// lcd_scanline_mode_timer_top: dot-clock driven scan-line mode timer with apb config
// depends on lcdt_pkg, lcdt_in_if, lcdt_out_if
//
// usage:
//   in_ch carries one transaction per dot-clock tick with a halted flag; every
//   accepted tick gives exactly one transaction on out_ch with the mode, line,
//   line-compare match flag and the v-blank, stat and line-end pulses.
//   registers on the apb port: 0x0 display enable, 0x4 line compare,
//   0x8 match interrupt enable; write only while the timer is idle.
//   an accepted tick is held in the input register, then the mode/counter
//   update lands in the result register together with the new timer state.
//   throughput is one tick per cycle while out_ch takes results; the state
//   update is one short add, compare and select stage, so the next tick can follow at once.
//   when out_ch stalls, the result register holds and the input register
//   takes one more tick before in_ch.ready drops; no transaction is lost.
//   after reset: oam scan, line 0, counter 0, display enabled, compare 0.
//   no clearing pass is needed; the timer is usable from the first cycle.
//
module lcd_scanline_mode_timer_top (
  input  logic                     clk,
  input  logic                     rst,
  lcdt_in_if.sink                  in_ch,
  lcdt_out_if.source               out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [lcdt_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdt_pkg::DATA_W-1:0] pwdata,
  output logic [lcdt_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import lcdt_pkg::*;

  // configuration registers
  logic              display_enable;
  logic [LINE_W-1:0] line_compare;
  logic              match_irq_enable;
  reg_idx_t          reg_idx;

  // timer state; phase tracks dot_count modulo the line length in v-blank
  mode_t              mode_reg, mode_next;
  logic [DOT_W-1:0]   dot_count, dot_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [LINE_W-1:0]  line_reg, line_next;
  logic               match_flag, match_next;

  // input register
  logic s1_valid;
  logic s1_halted;

  // result register
  logic              r_valid;
  mode_t             r_mode;
  logic [LINE_W-1:0] r_line;
  logic              r_match;
  logic              r_vblank;
  logic              r_stat;
  logic              r_end;

  logic               advance;
  logic               run;
  logic [DOT_W-1:0]   dot_inc;
  logic [PHASE_W-1:0] phase_inc;
  logic [LINE_W-1:0]  line_inc;
  logic               vblank_pulse, stat_level, end_pulse;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable   <= 1'b1;
      line_compare     <= '0;
      match_irq_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_DISPLAY_ENABLE:   display_enable   <= pwdata[0];
        REG_LINE_COMPARE:     line_compare     <= pwdata[LINE_W-1:0];
        REG_MATCH_IRQ_ENABLE: match_irq_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DISPLAY_ENABLE:   prdata[0]          = display_enable;
      REG_LINE_COMPARE:     prdata[LINE_W-1:0] = line_compare;
      REG_MATCH_IRQ_ENABLE: prdata[0]          = match_irq_enable;
      default: ;
    endcase
  end

  // handshake: result register frees when empty or taken
  assign advance      = s1_valid && (!r_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_halted <= in_ch.halted;
    end
  end

  assign run       = !s1_halted && display_enable;
  assign dot_inc   = dot_count + DOT_W'(1);
  assign phase_inc = (phase == PHASE_W'(LINE_DOTS - 1)) ? '0 : phase + PHASE_W'(1);
  assign line_inc  = line_reg + LINE_W'(1);

  always_comb begin
    mode_next    = mode_reg;
    dot_next     = dot_count;
    phase_next   = phase;
    line_next    = line_reg;
    match_next   = match_flag;
    vblank_pulse = 1'b0;
    stat_level   = 1'b0;
    end_pulse    = 1'b0;
    if (run) begin
      dot_next   = dot_inc;
      phase_next = phase_inc;
      unique case (mode_reg)
        MODE_OAM: begin
          if (dot_inc >= DOT_W'(OAM_DOTS)) begin
            dot_next   = '0;
            phase_next = '0;
            mode_next  = MODE_DRAW;
          end
        end
        MODE_DRAW: begin
          if (dot_inc >= DOT_W'(DRAW_DOTS)) begin
            dot_next   = '0;
            phase_next = '0;
            mode_next  = MODE_HBLANK;
          end
        end
        MODE_HBLANK: begin
          if (dot_inc >= DOT_W'(HBLANK_DOTS)) begin
            dot_next   = '0;
            phase_next = '0;
            end_pulse  = 1'b1;
            line_next  = line_inc;
            mode_next  = (line_inc == LINE_W'(VISIBLE_LINES)) ? MODE_VBLANK : MODE_OAM;
          end
        end
        MODE_VBLANK: begin
          if (line_reg == LINE_W'(VISIBLE_LINES) && dot_inc == DOT_W'(1)) begin
            vblank_pulse = 1'b1;
          end
          // line advances each time the counter reaches a whole line
          if (phase_inc == '0) begin
            line_next = line_inc;
          end
          if (line_next == LINE_W'(LAST_LINE)) begin
            dot_next   = '0;
            phase_next = '0;
            line_next  = '0;
            mode_next  = MODE_OAM;
          end
        end
        default: ;
      endcase
      match_next = (line_next == line_compare);
      stat_level = match_next && match_irq_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= MODE_OAM;
      dot_count  <= '0;
      phase      <= '0;
      line_reg   <= '0;
      match_flag <= 1'b0;
    end else if (advance) begin
      mode_reg   <= mode_next;
      dot_count  <= dot_next;
      phase      <= phase_next;
      line_reg   <= line_next;
      match_flag <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (out_ch.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_mode   <= mode_next;
      r_line   <= line_next;
      r_match  <= match_next;
      r_vblank <= vblank_pulse;
      r_stat   <= stat_level;
      r_end    <= end_pulse;
    end
  end

  assign out_ch.valid      = r_valid;
  assign out_ch.mode       = r_mode;
  assign out_ch.line       = r_line;
  assign out_ch.line_match = r_match;
  assign out_ch.vblank_irq = r_vblank;
  assign out_ch.stat_irq   = r_stat;
  assign out_ch.line_end   = r_end;

endmodule

@@ tb/sv/lcdt_tb_pkg.sv @@
`timescale 1ns / 100ps
// lcdt_tb_pkg: scan-line timing predictor and result scoreboard for the mode timer bench
// depends on lcdt_pkg (mode and register index enums)
package lcdt_tb_pkg;
  import lcdt_pkg::*;

  // expected timing, kept apart from the design package
  localparam int unsigned OAM_LEN        = 80;
  localparam int unsigned DRAW_LEN       = 172;
  localparam int unsigned HBLANK_LEN     = 204;
  localparam int unsigned VBLANK_START   = 144;
  localparam int unsigned WRAP_LINE      = 153;
  localparam int unsigned VBLANK_LINE_LEN = 456;
  localparam int unsigned MAX_PRINTED    = 100;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] line;
    logic       line_match;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_end;
  } timer_result_t;

  class timer_scoreboard;
    bit            display_on;
    logic [7:0]    compare_line;
    bit            match_irq_on;
    mode_t         cur_mode;
    logic [12:0]   dots;
    logic [7:0]    cur_line;
    logic          match;
    timer_result_t pending_q[$];
    int            errors;
    int            results_seen;

    function new();
      display_on   = 1'b1;
      compare_line = 8'd0;
      match_irq_on = 1'b0;
      cur_mode     = MODE_OAM;
      dots         = '0;
      cur_line     = '0;
      match        = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_DISPLAY_ENABLE:   display_on = data[0];
        REG_LINE_COMPARE:     compare_line = data[7:0];
        REG_MATCH_IRQ_ENABLE: match_irq_on = data[0];
        default: ;
      endcase
    endfunction

    // advance the timer by one accepted tick and queue the result it gives
    function void note_tick(bit halted);
      timer_result_t r;
      r = '0;
      if (!halted && display_on) begin
        dots = dots + 13'd1;
        case (cur_mode)
          MODE_OAM: begin
            if (dots >= OAM_LEN) begin
              dots = '0;
              cur_mode = MODE_DRAW;
            end
          end
          MODE_DRAW: begin
            if (dots >= DRAW_LEN) begin
              dots = '0;
              cur_mode = MODE_HBLANK;
            end
          end
          MODE_HBLANK: begin
            if (dots >= HBLANK_LEN) begin
              dots = '0;
              r.line_end = 1'b1;
              cur_line = cur_line + 8'd1;
              if (cur_line == VBLANK_START) cur_mode = MODE_VBLANK;
              else cur_mode = MODE_OAM;
            end
          end
          default: begin
            // v-blank counter runs on across lines, line steps every full line
            if (cur_line == VBLANK_START && dots == 13'd1) r.vblank_irq = 1'b1;
            if (dots % VBLANK_LINE_LEN == 0) cur_line = cur_line + 8'd1;
            if (cur_line == WRAP_LINE) begin
              dots = '0;
              cur_line = '0;
              cur_mode = MODE_OAM;
            end
          end
        endcase
        match = (cur_line == compare_line);
        r.stat_irq = match & match_irq_on;
      end
      r.mode = cur_mode;
      r.line = cur_line;
      r.line_match = match;
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(timer_result_t got);
      timer_result_t exp;
      if (pending_q.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
        results_seen++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.mode != exp.mode)
        report_mismatch($sformatf("mode %0d, wanted %0d", got.mode, exp.mode));
      if (got.line != exp.line)
        report_mismatch($sformatf("line %0d, wanted %0d", got.line, exp.line));
      if (got.line_match !== exp.line_match)
        report_mismatch($sformatf("line_match %b, wanted %b", got.line_match, exp.line_match));
      if (got.vblank_irq !== exp.vblank_irq)
        report_mismatch($sformatf("vblank_irq %b, wanted %b", got.vblank_irq, exp.vblank_irq));
      if (got.stat_irq !== exp.stat_irq)
        report_mismatch($sformatf("stat_irq %b, wanted %b", got.stat_irq, exp.stat_irq));
      if (got.line_end !== exp.line_end)
        report_mismatch($sformatf("line_end %b, wanted %b", got.line_end, exp.line_end));
      results_seen++;
    endtask
  endclass

endpackage

@@ tb/sv/tb_lcd_scanline_mode_timer_top.sv @@
`timescale 1ns / 100ps
// tb_lcd_scanline_mode_timer_top: drives dot ticks and apb writes into the mode timer
// and checks every result against lcdt_tb_pkg; depends on lcdt_pkg, lcdt_in_if, lcdt_out_if
module tb_lcd_scanline_mode_timer_top;
  import lcdt_pkg::*;
  import lcdt_tb_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int RAND_BLOCK  = 180;
  localparam int LONG_TICKS  = 100;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  lcdt_in_if  in_ch ();
  lcdt_out_if out_ch ();

  timer_scoreboard sb = new();

  bit hold_req = 1'b0;
  int sink_idle_pct = 30;
  int sink_calm = 0;
  int src_calm = 0;

  lcd_scanline_mode_timer_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_lcd_scanline_mode_timer_top: FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap(int pct, inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: ready pattern and checking
  initial begin
    int stall_left;
    logic nxt;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else begin
        stall_left = pick_gap(sink_idle_pct, sink_calm);
        nxt = (stall_left == 0);
        if (!nxt) stall_left--;
      end
      out_ch.ready <= nxt;
    end
  end

  initial begin
    timer_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.mode       = mode_t'(out_ch.mode);
        got.line       = out_ch.line;
        got.line_match = out_ch.line_match;
        got.vblank_irq = out_ch.vblank_irq;
        got.stat_irq   = out_ch.stat_irq;
        got.line_end   = out_ch.line_end;
        sb.check_result(got);
      end
    end
  end

  task send_tick(bit halted, int idle_pct);
    int gap;
    gap = pick_gap(idle_pct, src_calm);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.halted <= halted;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_tick(halted);
  endtask

  task run_ticks(int n, int halt_pct, int idle_pct);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, 99) < halt_pct, idle_pct);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task settle();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // unused upper bits carry random junk so masking gets checked too
  task apb_write(reg_idx_t idx, logic [31:0] val, int w);
    logic [31:0] data;
    data = ($urandom << w) | val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task pick_config();
    logic [7:0] cmp;
    case ($urandom_range(0, 5))
      0: cmp = 8'd0;
      1: cmp = 8'd1;
      2: cmp = 8'd2;
      3: cmp = 8'd255;
      default: cmp = 8'($urandom_range(0, 255));
    endcase
    apb_write(REG_DISPLAY_ENABLE, ($urandom_range(0, 3) != 0), 1);
    apb_write(REG_LINE_COMPARE, cmp, 8);
    apb_write(REG_MATCH_IRQ_ENABLE, $urandom_range(0, 1), 1);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.halted = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: compare 0 matches line 0, halted ticks hold everything
    send_tick(0, 0); send_tick(0, 0); send_tick(1, 0); send_tick(0, 0);
    send_tick(1, 0); send_tick(1, 0); send_tick(0, 0); send_tick(0, 0);
    run_ticks(0, 0, 0);
    settle();
    apb_write(REG_MATCH_IRQ_ENABLE, 1, 1);
    send_tick(0, 0); send_tick(0, 0); send_tick(1, 0);
    run_ticks(0, 0, 0);
    settle();
    // display off freezes the timer
    apb_write(REG_DISPLAY_ENABLE, 0, 1);
    send_tick(0, 0); send_tick(1, 0); send_tick(0, 0);
    run_ticks(0, 0, 0);
    settle();
    apb_write(REG_NONE, $urandom, 0);
    apb_write(REG_DISPLAY_ENABLE, 1, 1);
    apb_write(REG_LINE_COMPARE, 8'd1, 8);
    send_tick(0, 0); send_tick(0, 0); send_tick(0, 0); send_tick(1, 0);
    run_ticks(0, 0, 0);
    settle();

    // output held off while ticks keep coming, so the input side has to stall
    apb_write(REG_LINE_COMPARE, 8'd0, 8);
    hold_req = 1'b1;
    run_ticks(RAND_BLOCK, 20, 0);
    for (int b = 1; b < 5; b++) begin
      settle();
      pick_config();
      run_ticks(RAND_BLOCK, 20, 30);
    end

    // shorter runs with few stalls and compare set to lines 2, 3 and then 255
    settle();
    sink_idle_pct = 10;
    apb_write(REG_DISPLAY_ENABLE, 1, 1);
    apb_write(REG_LINE_COMPARE, 8'd2, 8);
    apb_write(REG_MATCH_IRQ_ENABLE, 1, 1);
    run_ticks(LONG_TICKS, 1, 10);
    settle();
    apb_write(REG_LINE_COMPARE, 8'd3, 8);
    run_ticks(LONG_TICKS, 1, 10);
    settle();
    apb_write(REG_LINE_COMPARE, 8'd255, 8);
    apb_write(REG_MATCH_IRQ_ENABLE, 0, 1);
    run_ticks(200, 20, 30);

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_lcd_scanline_mode_timer_top: PASS");
    end else begin
      $display("tb_lcd_scanline_mode_timer_top: FAIL");
    end
    $finish;
  end

endmodule

@@ lcd_scanline_mode_timer_top.f @@
hw/rtl/lcdt_pkg.sv
hw/rtl/lcdt_in_if.sv
hw/rtl/lcdt_out_if.sv
hw/rtl/lcd_scanline_mode_timer_top.sv
tb/sv/lcdt_tb_pkg.sv
tb/sv/tb_lcd_scanline_mode_timer_top.sv
